FILE: hdl/udwt_pkg.sv
// Package for the UTF-8 display width truncator.
// Holds field widths, lead byte codes, the width range table and the classify
// and saturating add functions. It depends on nothing.
package udwt_pkg;

    // Widths of the fields and the running sums.
    localparam int SUM_BITS       = 16;
    localparam int CP_BITS        = 21;
    localparam int MAX_WIDTH_BITS = 15;

    localparam logic [MAX_WIDTH_BITS-1:0] MAX_WIDTH_RESET = 15'd80;

    // Lead byte masks and the codes they must match.
    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Display width codes.
    localparam logic signed [2:0] W_CTRL   = -3'sd1;
    localparam logic signed [2:0] W_ZERO   = 3'sd0;
    localparam logic signed [2:0] W_NARROW = 3'sd1;
    localparam logic signed [2:0] W_WIDE   = 3'sd2;

    // One character handed from the decoder to the width stage.
    typedef struct packed {
        logic [CP_BITS-1:0] code_point;
        logic               forced_one;
        logic [2:0]         byte_length;
        logic               last_char;
    } t_char;

    // One inclusive code point range and its width.
    typedef struct packed {
        logic [CP_BITS-1:0] lo;
        logic [CP_BITS-1:0] hi;
        logic signed [2:0]  w;
    } t_range;

    localparam int NUM_RANGES = 80;

    // Ordered range list; the first range that holds the code point wins.
    localparam t_range WIDTH_TABLE [NUM_RANGES] = '{
        '{21'h000000, 21'h000000, W_ZERO}, '{21'h000001, 21'h00001F, W_CTRL},
        '{21'h00007F, 21'h00009F, W_CTRL},
        '{21'h000300, 21'h00036F, W_ZERO}, '{21'h001AB0, 21'h001AFF, W_ZERO},
        '{21'h001DC0, 21'h001DFF, W_ZERO},
        '{21'h0020D0, 21'h0020FF, W_ZERO}, '{21'h00FE20, 21'h00FE2F, W_ZERO},
        '{21'h000483, 21'h000489, W_ZERO},
        '{21'h00064B, 21'h00065F, W_ZERO}, '{21'h000670, 21'h000670, W_ZERO},
        '{21'h0006D6, 21'h0006DC, W_ZERO},
        '{21'h0006DF, 21'h0006E4, W_ZERO}, '{21'h0006E7, 21'h0006E8, W_ZERO},
        '{21'h0006EA, 21'h0006ED, W_ZERO},
        '{21'h000900, 21'h000903, W_ZERO}, '{21'h00093A, 21'h00093C, W_ZERO},
        '{21'h00093E, 21'h00094F, W_ZERO},
        '{21'h000951, 21'h000957, W_ZERO}, '{21'h000962, 21'h000963, W_ZERO},
        '{21'h000591, 21'h0005BD, W_ZERO},
        '{21'h0005BF, 21'h0005BF, W_ZERO}, '{21'h0005C1, 21'h0005C2, W_ZERO},
        '{21'h0005C4, 21'h0005C5, W_ZERO},
        '{21'h0005C7, 21'h0005C7, W_ZERO}, '{21'h000E31, 21'h000E31, W_ZERO},
        '{21'h000E34, 21'h000E3A, W_ZERO},
        '{21'h000E47, 21'h000E4E, W_ZERO}, '{21'h00200B, 21'h00200F, W_ZERO},
        '{21'h00202A, 21'h00202E, W_ZERO},
        '{21'h002060, 21'h002063, W_ZERO}, '{21'h002066, 21'h00206F, W_ZERO},
        '{21'h00FE00, 21'h00FE0F, W_ZERO},
        '{21'h0E0100, 21'h0E01EF, W_ZERO}, '{21'h00061C, 21'h00061C, W_ZERO},
        '{21'h00034F, 21'h00034F, W_ZERO},
        '{21'h00115F, 21'h001160, W_ZERO}, '{21'h0017B4, 21'h0017B5, W_ZERO},
        '{21'h00180B, 21'h00180D, W_ZERO},
        '{21'h00180F, 21'h00180F, W_ZERO}, '{21'h00FEFF, 21'h00FEFF, W_ZERO},
        '{21'h001100, 21'h00115F, W_WIDE}, '{21'h001161, 21'h0011FF, W_WIDE},
        '{21'h00A960, 21'h00A97C, W_WIDE},
        '{21'h00D7B0, 21'h00D7C6, W_WIDE}, '{21'h00D7CB, 21'h00D7FB, W_WIDE},
        '{21'h002E80, 21'h002EF3, W_WIDE},
        '{21'h002F00, 21'h002FD5, W_WIDE}, '{21'h002FF0, 21'h002FFB, W_WIDE},
        '{21'h003000, 21'h00303E, W_WIDE},
        '{21'h003040, 21'h0030FF, W_WIDE}, '{21'h003100, 21'h00312F, W_WIDE},
        '{21'h0031A0, 21'h0031E3, W_WIDE},
        '{21'h003400, 21'h004DBF, W_WIDE}, '{21'h004E00, 21'h009FFF, W_WIDE},
        '{21'h00A000, 21'h00A48C, W_WIDE},
        '{21'h00A490, 21'h00A4C6, W_WIDE}, '{21'h00AC00, 21'h00D7A3, W_WIDE},
        '{21'h00F900, 21'h00FAFF, W_WIDE},
        '{21'h00FE10, 21'h00FE19, W_WIDE}, '{21'h00FE30, 21'h00FE52, W_WIDE},
        '{21'h00FE54, 21'h00FE66, W_WIDE},
        '{21'h00FE68, 21'h00FE6B, W_WIDE}, '{21'h00FF01, 21'h00FF60, W_WIDE},
        '{21'h00FFE0, 21'h00FFE6, W_WIDE},
        '{21'h002329, 21'h00232A, W_WIDE}, '{21'h0000A2, 21'h0000A3, W_WIDE},
        '{21'h0000A5, 21'h0000A5, W_WIDE},
        '{21'h0000AC, 21'h0000AC, W_WIDE}, '{21'h0020A9, 21'h0020A9, W_WIDE},
        '{21'h020000, 21'h02A6DF, W_WIDE}, '{21'h02A700, 21'h02EBEF, W_WIDE},
        '{21'h02F800, 21'h02FA1F, W_WIDE},
        '{21'h030000, 21'h0323AF, W_WIDE},
        '{21'h01F300, 21'h01F64F, W_WIDE}, '{21'h01F680, 21'h01F6FF, W_WIDE},
        '{21'h01F900, 21'h01FAFF, W_WIDE},
        '{21'h002600, 21'h0027BF, W_WIDE}, '{21'h002300, 21'h0023FF, W_WIDE},
        '{21'h0025A0, 21'h0025FF, W_WIDE}
    };

    // All ranges are compared in parallel; walking from the end keeps the
    // first match, and a code point outside every range is narrow.
    function automatic logic signed [2:0] classify(input logic [CP_BITS-1:0] cp);
        logic signed [2:0] w;
        w = W_NARROW;
        for (int i = NUM_RANGES - 1; i >= 0; i--) begin
            if (cp >= WIDTH_TABLE[i].lo && cp <= WIDTH_TABLE[i].hi) begin
                w = WIDTH_TABLE[i].w;
            end
        end
        return w;
    endfunction

    // Adds a small width to a sum and clamps to the signed sum range.
    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] a,
        input logic signed [2:0]          b
    );
        logic signed [SUM_BITS:0] s;
        s = {a[SUM_BITS-1], a} + {{(SUM_BITS-2){b[2]}}, b};
        if (s[SUM_BITS] != s[SUM_BITS-1]) begin
            if (s[SUM_BITS]) begin
                return {1'b1, {(SUM_BITS-1){1'b0}}};
            end else begin
                return {1'b0, {(SUM_BITS-1){1'b1}}};
            end
        end
        return s[SUM_BITS-1:0];
    endfunction

endpackage

FILE: hdl/udwt_if.sv
// Channel interfaces of the UTF-8 display width truncator: byte input and
// character result. Depends on udwt_pkg for the field widths.
interface udwt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface udwt_out_if import udwt_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [CP_BITS-1:0]         code_point;
    logic signed [2:0]          disp_width;
    logic [2:0]                 byte_length;
    logic signed [SUM_BITS-1:0] total_width;
    logic                       keep;
    logic                       last_char;

    modport source (output valid, output code_point, output disp_width,
                    output byte_length, output total_width, output keep,
                    output last_char, input ready);
    modport sink   (input valid, input code_point, input disp_width,
                    input byte_length, input total_width, input keep,
                    input last_char, output ready);
endinterface

FILE: hdl/udwt_decoder.sv
// Byte stage: gathers UTF-8 bytes into code points and registers each
// finished character. Depends on udwt_pkg and udwt_in_if.
module udwt_decoder import udwt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    udwt_in_if.sink   i_in,
    output logic      o_char_valid,
    output t_char     o_char,
    input  logic      i_char_ready
);

    logic [CP_BITS-1:0] r_partial_point;
    logic [1:0]         r_bytes_left;
    logic [2:0]         r_char_length;
    logic               r_char_valid;
    t_char              r_char;

    logic [CP_BITS-1:0] n_partial_point;
    logic [1:0]         n_bytes_left;
    logic [2:0]         n_char_length;
    logic               forced_one;
    logic [CP_BITS-1:0] cont_bits;
    logic               char_done;
    logic               accept;
    logic [7:0]         b;

    // The register frees up when it is empty or its character moves on.
    assign i_in.ready = !r_char_valid || i_char_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    // Lead byte decode or continuation merge for the byte on the input.
    always_comb begin
        n_partial_point = r_partial_point;
        n_bytes_left    = r_bytes_left;
        n_char_length   = r_char_length;
        forced_one      = 1'b0;
        cont_bits       = '0;
        if (r_bytes_left == 2'd0) begin
            if ((b & LEAD1_MASK) == 8'h00) begin
                n_char_length   = 3'd1;
                n_partial_point = {13'b0, b};
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                n_char_length   = 3'd2;
                n_bytes_left    = 2'd1;
                n_partial_point = {10'b0, b[4:0], 6'b0};
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                n_char_length   = 3'd3;
                n_bytes_left    = 2'd2;
                n_partial_point = {5'b0, b[3:0], 12'b0};
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
                n_char_length   = 3'd4;
                n_bytes_left    = 2'd3;
                n_partial_point = {b[2:0], 18'b0};
            end else begin
                // Invalid lead: a one-byte character carrying the raw byte.
                n_char_length   = 3'd1;
                n_partial_point = {13'b0, b};
                forced_one      = 1'b1;
            end
        end else begin
            n_bytes_left = r_bytes_left - 2'd1;
            case (n_bytes_left)
                2'd0:    cont_bits = {15'b0, b[5:0]};
                2'd1:    cont_bits = {9'b0, b[5:0], 6'b0};
                2'd2:    cont_bits = {3'b0, b[5:0], 12'b0};
                default: cont_bits = '0;
            endcase
            n_partial_point = r_partial_point | cont_bits;
        end
        char_done = (n_bytes_left == 2'd0) || i_in.string_end;
    end

    // Decoder state and the valid flag of the character register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial_point <= '0;
            r_bytes_left    <= 2'd0;
            r_char_length   <= 3'd1;
            r_char_valid    <= 1'b0;
        end else begin
            if (i_char_ready) begin
                r_char_valid <= 1'b0;
            end
            if (accept) begin
                if (char_done) begin
                    r_partial_point <= '0;
                    r_bytes_left    <= 2'd0;
                    r_char_length   <= 3'd1;
                    r_char_valid    <= 1'b1;
                end else begin
                    r_partial_point <= n_partial_point;
                    r_bytes_left    <= n_bytes_left;
                    r_char_length   <= n_char_length;
                end
            end
        end
    end

    // Character payload; missing bytes stay zero and are not counted.
    always_ff @(posedge i_clk) begin
        if (accept && char_done) begin
            r_char.code_point  <= n_partial_point;
            r_char.forced_one  <= forced_one;
            r_char.byte_length <= n_char_length - {1'b0, n_bytes_left};
            r_char.last_char   <= i_in.string_end;
        end
    end

    assign o_char_valid = r_char_valid;
    assign o_char       = r_char;

    // A character in progress always has fewer bytes left than its length.
    a_left_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_bytes_left} < r_char_length)
        else $error("bytes left not below character length");

    // The end of a string always leaves the decoder at a character boundary.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.string_end |=> r_bytes_left == 2'd0)
        else $error("decoder not cleared after string end");

    // A registered character has at least one byte.
    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_valid |-> r_char.byte_length != 3'd0)
        else $error("character with zero byte length");

endmodule

FILE: hdl/udwt_width.sv
// Width stage: classifies each character, keeps the total and kept sums and
// holds the result register. Depends on udwt_pkg and udwt_out_if.
module udwt_width import udwt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_char_valid,
    input  t_char                     i_char,
    output logic                      o_char_ready,
    input  logic [MAX_WIDTH_BITS-1:0] i_max_width,
    udwt_out_if.source                o_out
);

    logic signed [SUM_BITS-1:0] r_sum_all;
    logic signed [SUM_BITS-1:0] r_sum_kept;
    logic                       r_cut_done;
    logic                       r_out_valid;
    logic [CP_BITS-1:0]         r_code_point;
    logic signed [2:0]          r_disp_width;
    logic [2:0]                 r_byte_length;
    logic signed [SUM_BITS-1:0] r_total_width;
    logic                       r_keep;
    logic                       r_last_char;

    logic signed [SUM_BITS-1:0] n_sum_all;
    logic signed [SUM_BITS-1:0] n_sum_kept;
    logic                       n_cut_done;
    logic signed [2:0]          w;
    logic signed [SUM_BITS:0]   kept_try;
    logic signed [SUM_BITS:0]   limit;
    logic                       fit;
    logic                       take;

    assign o_char_ready = !r_out_valid || o_out.ready;
    assign take         = i_char_valid && o_char_ready;

    // Width lookup, strict truncation test and the two saturating sums.
    always_comb begin
        w        = i_char.forced_one ? W_NARROW : classify(i_char.code_point);
        kept_try = {r_sum_kept[SUM_BITS-1], r_sum_kept} + {{(SUM_BITS-2){w[2]}}, w};
        limit    = {{(SUM_BITS+1-MAX_WIDTH_BITS){1'b0}}, i_max_width};
        fit      = !r_cut_done && (i_max_width != '0) && (kept_try <= limit);
        n_sum_all  = sat_add(r_sum_all, w);
        n_sum_kept = fit ? sat_add(r_sum_kept, w) : r_sum_kept;
        n_cut_done = r_cut_done || !fit;
    end

    // Sums and cut flag, cleared after the last character of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_all   <= '0;
            r_sum_kept  <= '0;
            r_cut_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_out_valid <= 1'b1;
                if (i_char.last_char) begin
                    r_sum_all  <= '0;
                    r_sum_kept <= '0;
                    r_cut_done <= 1'b0;
                end else begin
                    r_sum_all  <= n_sum_all;
                    r_sum_kept <= n_sum_kept;
                    r_cut_done <= n_cut_done;
                end
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_code_point  <= i_char.code_point;
            r_disp_width  <= w;
            r_byte_length <= i_char.byte_length;
            r_total_width <= n_sum_all;
            r_keep        <= fit;
            r_last_char   <= i_char.last_char;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.code_point  = r_code_point;
    assign o_out.disp_width  = r_disp_width;
    assign o_out.byte_length = r_byte_length;
    assign o_out.total_width = r_total_width;
    assign o_out.keep        = r_keep;
    assign o_out.last_char   = r_last_char;

    // Once cut, a character of the same string is never kept.
    a_cut_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_cut_done |=> !r_keep)
        else $error("character kept after the cut");

    // An invalid lead always comes out one column wide.
    a_forced_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_char.forced_one |=> r_disp_width == W_NARROW)
        else $error("invalid lead not narrow");

    // A kept result implies a nonzero limit.
    a_keep_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && fit |-> i_max_width != '0)
        else $error("character kept under a zero limit");

endmodule

FILE: hdl/utf8_display_width_truncator.sv
// Top level of the UTF-8 display width truncator: the limit register and the
// two pipeline stages. Depends on udwt_pkg, udwt_if, udwt_decoder, udwt_width.
//
// The block takes one string byte per cycle, without gaps, while the character
// register can move on, and gives one transaction for each finished
// character: its code point, display width, byte count, running total width
// and keep flag. A character's result is held first in the byte decoder
// register and then in the width stage's result register, where all range
// compares run in parallel ahead of the saturating sums. Bytes inside a
// character give no result. A stalled result holds both stages; the input
// keeps flowing as long as the character register can move on. The limit
// register is written with i_cfg_we and resets to 80 columns.
module utf8_display_width_truncator import udwt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    udwt_in_if.sink                   i_in,
    udwt_out_if.source                o_out,
    input  logic                      i_cfg_we,
    input  logic [MAX_WIDTH_BITS-1:0] i_cfg_data
);

    logic [MAX_WIDTH_BITS-1:0] r_max_width;
    logic                      char_valid;
    logic                      char_ready;
    t_char                     char_item;

    // Column limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= MAX_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_max_width <= i_cfg_data;
        end
    end

    // Byte decoder stage.
    udwt_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_char_valid (char_valid),
        .o_char       (char_item),
        .i_char_ready (char_ready)
    );

    // Width and truncation stage.
    udwt_width u_width (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (char_valid),
        .i_char       (char_item),
        .o_char_ready (char_ready),
        .i_max_width  (r_max_width),
        .o_out        (o_out)
    );

endmodule
